// File: src/cell_balance_and_fail_manager_top_assert.svh
// Assertion macros for the cell balance and failure manager.
// Used by cell_balance_and_fail_manager_top; expects clk and arst_n in scope.
`ifndef CELL_BALANCE_AND_FAIL_MANAGER_TOP_ASSERT_SVH
`define CELL_BALANCE_AND_FAIL_MANAGER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CBFM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CBFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/cbfm_pkg.sv
// Shared constants and types of the cell balance and failure manager.
// No dependencies.
`default_nettype none

package cbfm_pkg;

	// parameter defaults
	localparam int NumCellsDef       = 16;
	localparam int FailDelayTicksDef = 1000;
	localparam int BalPeriodTicksDef = 50;
	localparam int StatusHoldDef     = 500;
	localparam int HoldDiv           = 5;

	localparam int MvW   = 16;
	localparam int TempW = 16;
	localparam int CellW = 4;
	localparam int CntW  = 16;
	localparam int RegIdxW = 3;

	// register indexes
	localparam logic [RegIdxW-1:0] REG_FAIL_DIFF    = 3'd0;
	localparam logic [RegIdxW-1:0] REG_RECOVER_DIFF = 3'd1;
	localparam logic [RegIdxW-1:0] REG_START_DIFF   = 3'd2;
	localparam logic [RegIdxW-1:0] REG_END_DIFF     = 3'd3;
	localparam logic [RegIdxW-1:0] REG_START_MV     = 3'd4;
	localparam logic [RegIdxW-1:0] REG_START_TEMP   = 3'd5;
	localparam logic [RegIdxW-1:0] REG_END_TEMP     = 3'd6;

	// opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// failure machine
	localparam logic [1:0] FS_COMMON = 2'd0;
	localparam logic [1:0] FS_WAIT   = 2'd1;
	localparam logic [1:0] FS_FAILED = 2'd2;

	// balancing machine
	localparam logic BAL_IDLE = 1'b0;
	localparam logic BAL_ON   = 1'b1;

	typedef struct packed {
		logic [CntW-1:0]  cell_count;
		logic             count_event;
		logic             cell_fail;
		logic [1:0]       fail_state;
		logic             bleed_on;
		logic [CellW-1:0] balance_cell;
		logic             balance_active;
	} result_t;

endpackage

`default_nettype wire

// File: src/cbfm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cbfm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: src/cell_balance_and_fail_manager_top.sv
// Cell balance and failure manager: one result beat per input beat.
// Results are registered in the output register, or parked in a skid stage on a stall.
// Throughput: one beat per cycle while the skid stage is empty; the period count store
// is a registered RAM read kept at the current cell, with a forward of the last write.
// Reset (arst_n low): thresholds to defaults, both machines idle, timers
// preloaded; period counts read zero through per-cell valid flops.
`default_nettype none

module cell_balance_and_fail_manager_top #(
	parameter int NUM_CELLS            = cbfm_pkg::NumCellsDef,
	parameter int FAIL_DELAY_TICKS     = cbfm_pkg::FailDelayTicksDef,
	parameter int BALANCE_PERIOD_TICKS = cbfm_pkg::BalPeriodTicksDef,
	parameter int STATUS_HOLD_TICKS    = cbfm_pkg::StatusHoldDef
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire [2:0]   cfg_addr,
	input  wire [15:0]  cfg_wdata,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// max_mv, min_mv, max_cell, temp_lo, temp_hi, sample_done, mode_ok, measuring
	input  wire [71:0]  s_axis_tdata,
	// opcode
	input  wire [0:0]   s_axis_tuser,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// balance_active, balance_cell, bleed_on, fail_state, cell_fail, count_event,
	// cell_count
	output logic [31:0] m_axis_tdata
);

	localparam int FailW   = $clog2(FAIL_DELAY_TICKS + 1);
	localparam int PerW    = $clog2(BALANCE_PERIOD_TICKS + 1);
	localparam int HoldW   = $clog2(STATUS_HOLD_TICKS + 1);
	localparam int HoldLow = STATUS_HOLD_TICKS / cbfm_pkg::HoldDiv;
	localparam int AddrW   = $clog2(NUM_CELLS);
	localparam int MvW     = cbfm_pkg::MvW;
	localparam int CellW   = cbfm_pkg::CellW;
	localparam int CntW    = cbfm_pkg::CntW;

	localparam logic [FailW-1:0] FailLoad = FailW'(FAIL_DELAY_TICKS);
	localparam logic [PerW-1:0]  PerLoad  = PerW'(BALANCE_PERIOD_TICKS);
	localparam logic [HoldW-1:0] HoldLoad = HoldW'(STATUS_HOLD_TICKS);
	localparam logic [HoldW-1:0] HoldRst  = HoldW'(HoldLow);
	localparam logic [CellW-1:0] LastCell = CellW'(NUM_CELLS - 1);
	localparam logic [CntW-1:0]  CntMax   = {CntW{1'b1}};

	// input fields
	logic                    opcode;
	logic [MvW-1:0]          max_mv, min_mv;
	logic [CellW-1:0]        max_cell;
	logic signed [15:0]      temp_lo, temp_hi;
	logic                    sample_done, mode_ok, measuring;

	assign opcode      = s_axis_tuser[0];
	assign max_mv      = s_axis_tdata[15:0];
	assign min_mv      = s_axis_tdata[31:16];
	assign max_cell    = s_axis_tdata[35:32];
	assign temp_lo     = s_axis_tdata[51:36];
	assign temp_hi     = s_axis_tdata[67:52];
	assign sample_done = s_axis_tdata[68];
	assign mode_ok     = s_axis_tdata[69];
	assign measuring   = s_axis_tdata[70];

	// configuration
	logic [MvW-1:0]     fail_diff_q, recover_diff_q, start_diff_q, end_diff_q, start_mv_q;
	logic signed [15:0] start_temp_q, end_temp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_diff_q    <= 16'd500;
			recover_diff_q <= 16'd300;
			start_diff_q   <= 16'd30;
			end_diff_q     <= 16'd10;
			start_mv_q     <= 16'd3400;
			start_temp_q   <= 16'sd0;
			end_temp_q     <= 16'sd450;
		end else if (cfg_we) begin
			case (cfg_addr)
				cbfm_pkg::REG_FAIL_DIFF:    fail_diff_q    <= cfg_wdata;
				cbfm_pkg::REG_RECOVER_DIFF: recover_diff_q <= cfg_wdata;
				cbfm_pkg::REG_START_DIFF:   start_diff_q   <= cfg_wdata;
				cbfm_pkg::REG_END_DIFF:     end_diff_q     <= cfg_wdata;
				cbfm_pkg::REG_START_MV:     start_mv_q     <= cfg_wdata;
				cbfm_pkg::REG_START_TEMP:   start_temp_q   <= cfg_wdata;
				cbfm_pkg::REG_END_TEMP:     end_temp_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// state
	logic             bal_q, bal_d;
	logic [1:0]       fail_st_q, fail_st_d;
	logic [FailW-1:0] fail_tmr_q, fail_tmr_d;
	logic [PerW-1:0]  per_tmr_q, per_tmr_d;
	logic [HoldW-1:0] hold_tmr_q, hold_tmr_d;
	logic [CellW-1:0] cur_cell_q, cur_cell_d;
	logic             paused_q, paused_d;
	logic             switch_q, switch_d;

	// count store: RAM + valid bits + forward of last write
	logic [NUM_CELLS-1:0] cnt_vld_q;
	logic                 fwd_vld_q;
	logic [AddrW-1:0]     fwd_addr_q;
	logic [CntW-1:0]      fwd_data_q;
	logic [CntW-1:0]      ram_rdata;
	logic [AddrW-1:0]     cur_addr, rd_addr;
	logic [CntW-1:0]      cnt_cur, cnt_new;
	logic                 cnt_we;

	logic accept;
	logic out_vld_q, skid_vld_q;
	cbfm_pkg::result_t res, out_q, skid_q;

	assign accept = s_axis_tvalid & s_axis_tready;

	assign cur_addr = AddrW'(cur_cell_q);
	assign rd_addr  = accept ? AddrW'(cur_cell_d) : cur_addr;

	cbfm_ram #(
		.WIDTH(CntW),
		.DEPTH(NUM_CELLS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cur_addr),
		.wdata(cnt_new),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (!cnt_vld_q[cur_addr]) begin
			cnt_cur = '0;
		end else if (fwd_vld_q && fwd_addr_q == cur_addr) begin
			cnt_cur = fwd_data_q;
		end else begin
			cnt_cur = ram_rdata;
		end
		cnt_new = (cnt_cur == CntMax) ? cnt_cur : cnt_cur + 1'b1;
	end

	// item evaluation
	logic [CellW-1:0] mcell;
	logic [MvW-1:0]   spread;
	logic             fail_cond, recover_cond, ready, allow_on, allow_off, count_ev;

	always_comb begin
		mcell        = ({28'd0, max_cell} >= 32'(NUM_CELLS)) ? LastCell : max_cell;
		spread       = (max_mv >= min_mv) ? max_mv - min_mv : '0;
		fail_cond    = {1'b0, max_mv} >= ({1'b0, fail_diff_q} + {1'b0, min_mv});
		recover_cond = {1'b0, max_mv} < ({1'b0, recover_diff_q} + {1'b0, min_mv});
		ready        = sample_done & mode_ok;
		allow_on  = (spread >= start_diff_q) && (max_mv >= start_mv_q) &&
		            (temp_lo >= start_temp_q) && (temp_hi <= end_temp_q);
		allow_off = (spread <= end_diff_q) || (max_mv <= start_mv_q) ||
		            (temp_lo < start_temp_q) || (temp_hi > end_temp_q);

		bal_d      = bal_q;
		fail_st_d  = fail_st_q;
		fail_tmr_d = fail_tmr_q;
		per_tmr_d  = per_tmr_q;
		hold_tmr_d = hold_tmr_q;
		cur_cell_d = cur_cell_q;
		paused_d   = paused_q;
		switch_d   = switch_q;
		count_ev   = 1'b0;

		if (opcode == cbfm_pkg::OP_TICK) begin
			if (per_tmr_q != '0)  per_tmr_d  = per_tmr_q - 1'b1;
			if (fail_tmr_q != '0) fail_tmr_d = fail_tmr_q - 1'b1;
			if (hold_tmr_q != '0) hold_tmr_d = hold_tmr_q - 1'b1;
		end else begin
			case (fail_st_q)
				cbfm_pkg::FS_COMMON: begin
					if (fail_cond) begin
						fail_st_d  = cbfm_pkg::FS_WAIT;
						fail_tmr_d = FailLoad;
					end
				end
				cbfm_pkg::FS_WAIT: begin
					if (fail_cond) begin
						if (fail_tmr_q == '0) fail_st_d = cbfm_pkg::FS_FAILED;
					end else begin
						fail_st_d  = cbfm_pkg::FS_COMMON;
						fail_tmr_d = '0;
					end
				end
				default: begin
					if (recover_cond) fail_st_d = cbfm_pkg::FS_COMMON;
				end
			endcase

			if (ready) begin
				if (bal_q == cbfm_pkg::BAL_IDLE) begin
					if (allow_on) begin
						if (hold_tmr_q == '0 && !measuring) begin
							bal_d      = cbfm_pkg::BAL_ON;
							cur_cell_d = mcell;
							switch_d   = 1'b1;
							per_tmr_d  = PerLoad;
							hold_tmr_d = HoldLoad;
							paused_d   = 1'b0;
						end
					end else begin
						hold_tmr_d = HoldRst;
					end
				end else if (measuring) begin
					switch_d = 1'b0;
					paused_d = 1'b1;
				end else begin
					if (paused_q) begin
						switch_d = 1'b1;
						paused_d = 1'b0;
					end
					if (per_tmr_q == '0) begin
						count_ev = 1'b1;
						if (!allow_off) begin
							if (mcell != cur_cell_q) begin
								cur_cell_d = mcell;
								switch_d   = 1'b1;
							end
							per_tmr_d  = PerLoad;
							hold_tmr_d = HoldLoad;
						end else if (hold_tmr_q == '0) begin
							switch_d   = 1'b0;
							bal_d      = cbfm_pkg::BAL_IDLE;
							cur_cell_d = '0;
							per_tmr_d  = '0;
						end
					end
				end
			end else begin
				if (bal_q == cbfm_pkg::BAL_ON) begin
					switch_d   = 1'b0;
					cur_cell_d = '0;
				end
				bal_d      = cbfm_pkg::BAL_IDLE;
				hold_tmr_d = HoldRst;
			end
		end

		res.balance_active = bal_d;
		res.balance_cell   = cur_cell_d;
		res.bleed_on       = switch_d;
		res.fail_state     = fail_st_d;
		res.cell_fail      = (fail_st_d == cbfm_pkg::FS_FAILED);
		res.count_event    = count_ev;
		res.cell_count     = count_ev ? cnt_new : '0;
	end

	assign cnt_we = accept & count_ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bal_q      <= cbfm_pkg::BAL_IDLE;
			fail_st_q  <= cbfm_pkg::FS_COMMON;
			fail_tmr_q <= FailLoad;
			per_tmr_q  <= PerLoad;
			hold_tmr_q <= HoldRst;
			cur_cell_q <= '0;
			paused_q   <= 1'b0;
			switch_q   <= 1'b0;
			cnt_vld_q  <= '0;
			fwd_vld_q  <= 1'b0;
		end else begin
			fwd_vld_q <= cnt_we;
			if (accept) begin
				bal_q      <= bal_d;
				fail_st_q  <= fail_st_d;
				fail_tmr_q <= fail_tmr_d;
				per_tmr_q  <= per_tmr_d;
				hold_tmr_q <= hold_tmr_d;
				cur_cell_q <= cur_cell_d;
				paused_q   <= paused_d;
				switch_q   <= switch_d;
			end
			if (cnt_we) begin
				cnt_vld_q[cur_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			fwd_addr_q <= cur_addr;
			fwd_data_q <= cnt_new;
		end
	end

	// output register with skid stage
	assign s_axis_tready = !skid_vld_q;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'd0, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_axis_tready) begin
			out_vld_q  <= skid_vld_q | accept;
			skid_vld_q <= 1'b0;
		end else if (accept) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_axis_tready) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	`include "cell_balance_and_fail_manager_top_assert.svh"

	`CBFM_ASSERT_NOW(a_skid_behind_out, skid_vld_q, out_vld_q,
		"skid stage holds a beat while output register is empty")
	`CBFM_ASSERT_NOW(a_idle_quiet, bal_q == cbfm_pkg::BAL_IDLE,
		cur_cell_q == '0 && !switch_q, "idle balancer has a cell or closed switch")
	`CBFM_ASSERT_NOW(a_count_zero, out_vld_q && !out_q.count_event,
		out_q.cell_count == '0, "cell count reported without a count event")
	`CBFM_ASSERT_NEXT(a_stall_to_skid, accept && out_vld_q && !m_axis_tready,
		skid_vld_q, "beat accepted under stall was not parked in skid stage")

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking bench for cell_balance_and_fail_manager_top: stream beats in, result beats
// out, checked against a behavioral scoreboard that tracks both state machines.
// Depends on cbfm_pkg and the top-level RTL only.

import cbfm_pkg::*;

typedef struct {
	logic        op;
	logic [15:0] max_mv;
	logic [15:0] min_mv;
	logic [3:0]  max_cell;
	logic [15:0] temp_lo;
	logic [15:0] temp_hi;
	logic        sample_done;
	logic        mode_ok;
	logic        measuring;
} beat_t;

typedef enum {SPREAD_SMALL, SPREAD_MID, SPREAD_LARGE, SPREAD_INVERTED} spread_kind_e;
typedef enum {SET_TYPICAL, SET_LOW, SET_HIGH} setting_e;

class balance_scoreboard;
	int fail_diff, recover_diff, start_diff, end_diff, start_mv_th;
	int start_temp_th, end_temp_th;
	logic bal_on;
	logic [1:0] fstate;
	int fail_tmr, period_tmr, hold_tmr;
	logic [3:0] cur_cell;
	logic paused, closed;
	logic [15:0] period_cnt [NumCellsDef];
	result_t expected_q[$];
	int errors;

	function new();
		fail_diff = 500;
		recover_diff = 300;
		start_diff = 30;
		end_diff = 10;
		start_mv_th = 3400;
		start_temp_th = 0;
		end_temp_th = 450;
		bal_on = BAL_IDLE;
		fstate = FS_COMMON;
		fail_tmr = FailDelayTicksDef;
		period_tmr = BalPeriodTicksDef;
		hold_tmr = StatusHoldDef / HoldDiv;
		cur_cell = '0;
		paused = 1'b0;
		closed = 1'b0;
		foreach (period_cnt[i]) period_cnt[i] = '0;
		errors = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [15:0] v);
		case (idx)
			REG_FAIL_DIFF:    fail_diff = v;
			REG_RECOVER_DIFF: recover_diff = v;
			REG_START_DIFF:   start_diff = v;
			REG_END_DIFF:     end_diff = v;
			REG_START_MV:     start_mv_th = v;
			REG_START_TEMP:   start_temp_th = $signed(v);
			REG_END_TEMP:     end_temp_th = $signed(v);
			default: ;
		endcase
	endfunction

	function void note_beat(logic op, logic [71:0] d);
		int vmax, vmin, spread, mcell, tmin, tmax;
		bit ready, meas, fail_cond, allow_on, allow_off, cnt_ev;
		logic [15:0] cnt_val;
		result_t r;
		cnt_ev = 1'b0;
		cnt_val = '0;
		if (op == OP_TICK) begin
			if (period_tmr != 0) period_tmr--;
			if (fail_tmr != 0) fail_tmr--;
			if (hold_tmr != 0) hold_tmr--;
		end else begin
			vmax = d[15:0];
			vmin = d[31:16];
			mcell = d[35:32];
			if (mcell >= NumCellsDef) mcell = NumCellsDef - 1;
			tmin = $signed(d[51:36]);
			tmax = $signed(d[67:52]);
			ready = d[68] && d[69];
			meas = d[70];
			spread = (vmax >= vmin) ? vmax - vmin : 0;
			fail_cond = vmax >= fail_diff + vmin;

			case (fstate)
				FS_COMMON: if (fail_cond) begin
					fstate = FS_WAIT;
					fail_tmr = FailDelayTicksDef;
				end
				FS_WAIT: if (fail_cond) begin
					if (fail_tmr == 0) fstate = FS_FAILED;
				end else begin
					fstate = FS_COMMON;
					fail_tmr = 0;
				end
				default: if (vmax < recover_diff + vmin) fstate = FS_COMMON;
			endcase

			allow_on = spread >= start_diff && vmax >= start_mv_th &&
				tmin >= start_temp_th && tmax <= end_temp_th;
			allow_off = spread <= end_diff || vmax <= start_mv_th ||
				tmin < start_temp_th || tmax > end_temp_th;

			if (!ready) begin
				if (bal_on == BAL_ON) begin
					closed = 1'b0;
					cur_cell = '0;
				end
				bal_on = BAL_IDLE;
				hold_tmr = StatusHoldDef / HoldDiv;
			end else if (bal_on == BAL_IDLE) begin
				if (!allow_on) begin
					hold_tmr = StatusHoldDef / HoldDiv;
				end else if (hold_tmr == 0 && !meas) begin
					bal_on = BAL_ON;
					cur_cell = 4'(mcell);
					closed = 1'b1;
					period_tmr = BalPeriodTicksDef;
					hold_tmr = StatusHoldDef;
					paused = 1'b0;
				end
			end else if (meas) begin
				// bleed switch opens while the measurement runs
				closed = 1'b0;
				paused = 1'b1;
			end else begin
				if (paused) begin
					closed = 1'b1;
					paused = 1'b0;
				end
				if (period_tmr == 0) begin
					if (period_cnt[cur_cell] != 16'hFFFF) period_cnt[cur_cell]++;
					cnt_val = period_cnt[cur_cell];
					cnt_ev = 1'b1;
					if (!allow_off) begin
						if (mcell != cur_cell) begin
							cur_cell = 4'(mcell);
							closed = 1'b1;
						end
						period_tmr = BalPeriodTicksDef;
						hold_tmr = StatusHoldDef;
					end else if (hold_tmr == 0) begin
						closed = 1'b0;
						bal_on = BAL_IDLE;
						cur_cell = '0;
						period_tmr = 0;
					end
				end
			end
		end
		r.balance_active = bal_on;
		r.balance_cell = cur_cell;
		r.bleed_on = closed;
		r.fail_state = fstate;
		r.cell_fail = (fstate == FS_FAILED);
		r.count_event = cnt_ev;
		r.cell_count = cnt_val;
		expected_q.push_back(r);
	endfunction

	function void cmp(string name, int e, int a);
		if (e != a) begin
			errors++;
			if (errors <= 40)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
		end
	endfunction

	function void check_beat(result_t got);
		result_t exp_r;
		if (expected_q.size() == 0) begin
			errors++;
			if (errors <= 40)
				$display("%0t: result beat with nothing pending, expected none, got %p",
					$time, got);
			return;
		end
		exp_r = expected_q.pop_front();
		cmp("balance_active", exp_r.balance_active, got.balance_active);
		cmp("balance_cell", exp_r.balance_cell, got.balance_cell);
		cmp("bleed_on", exp_r.bleed_on, got.bleed_on);
		cmp("fail_state", exp_r.fail_state, got.fail_state);
		cmp("cell_fail", exp_r.cell_fail, got.cell_fail);
		cmp("count_event", exp_r.count_event, got.count_event);
		cmp("cell_count", exp_r.cell_count, got.cell_count);
	endfunction
endclass

module tb;
	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_addr;
	logic [15:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic [0:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b1;
	logic [31:0] m_axis_tdata;

	balance_scoreboard sb;
	int burst_left = 0;
	int sent = 0;
	int rx_mode = 0;
	int rx_left = 0;

	cell_balance_and_fail_manager_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: switches between stall patterns after runs of random length
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= ~m_axis_tready;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.write_reg(cfg_addr, cfg_wdata);
			if (s_axis_tvalid && s_axis_tready) sb.note_beat(s_axis_tuser[0], s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) sb.check_beat(result_t'(m_axis_tdata[25:0]));
		end
	end

	function automatic int clip(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic logic [71:0] pack_beat(beat_t b);
		return {1'b0, b.measuring, b.mode_ok, b.sample_done, b.temp_hi, b.temp_lo,
			b.max_cell, b.min_mv, b.max_mv};
	endfunction

	function automatic beat_t mk_eval(int vmax, int vmin, int idx, int tmin, int tmax,
			bit sd, bit mo, bit meas);
		beat_t b;
		b.op = OP_EVAL;
		b.max_mv = vmax[15:0];
		b.min_mv = vmin[15:0];
		b.max_cell = idx[3:0];
		b.temp_lo = tmin[15:0];
		b.temp_hi = tmax[15:0];
		b.sample_done = sd;
		b.mode_ok = mo;
		b.measuring = meas;
		return b;
	endfunction

	function automatic beat_t rand_beat();
		return mk_eval($urandom, $urandom, $urandom, $urandom, $urandom,
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endfunction

	// eval beat shaped around the current thresholds
	function automatic beat_t plausible_beat(spread_kind_e kind, bit temps_ok, bit meas,
			bit above);
		int vmax, vmin, s, lo, hi, t1, t2;
		if (above)
			vmax = clip(sb.start_mv_th + int'($urandom_range(1, 300)), 0, 65535);
		else
			vmax = clip(sb.start_mv_th + int'($urandom_range(0, 400)) - 100, 0, 65535);
		case (kind)
			SPREAD_SMALL: s = $urandom_range(0, sb.end_diff);
			SPREAD_MID:   s = sb.start_diff + int'($urandom_range(0, 100));
			SPREAD_LARGE: s = sb.fail_diff + int'($urandom_range(0, 300));
			default:      s = -1 - int'($urandom_range(0, 50));
		endcase
		vmin = clip(vmax - s, 0, 65535);
		lo = sb.start_temp_th;
		hi = sb.end_temp_th;
		if (temps_ok && lo <= hi) begin
			t1 = lo + int'($urandom_range(0, hi - lo));
			t2 = t1 + int'($urandom_range(0, hi - t1));
		end else begin
			t1 = $urandom;
			t2 = $urandom;
		end
		return mk_eval(vmax, vmin, $urandom_range(0, 15), t1, t2, 1'b1, 1'b1, meas);
	endfunction

	task automatic send_beat(input beat_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
			gap = $urandom_range(1, 6);
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		burst_left--;
		s_axis_tdata = pack_beat(b);
		s_axis_tuser = b.op;
		s_axis_tvalid = 1'b1;
		sent++;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// tick beats carry random payload, which the block must ignore
	task automatic send_ticks(input int n);
		beat_t b;
		repeat (n) begin
			b = rand_beat();
			b.op = OP_TICK;
			send_beat(b);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		burst_left = 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [2:0] idx, input int v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = v[15:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic apply_setting(input setting_e s);
		int fd, rd, sd, ed, smv, st, et;
		case (s)
			SET_LOW: begin
				fd = 0; rd = 0; sd = 0; ed = 0; smv = 0; st = -32768; et = 32767;
			end
			SET_HIGH: begin
				fd = 65535; rd = 65535; sd = 65535; ed = 65535; smv = 65535;
				st = 32767; et = -32768;
			end
			default: begin
				fd = $urandom_range(300, 900);
				rd = $urandom_range(100, fd);
				sd = $urandom_range(10, 60);
				ed = $urandom_range(0, sd);
				smv = $urandom_range(3000, 3600);
				st = -int'($urandom_range(0, 100));
				et = $urandom_range(300, 600);
			end
		endcase
		write_cfg(REG_FAIL_DIFF, fd);
		write_cfg(REG_RECOVER_DIFF, rd);
		write_cfg(REG_START_DIFF, sd);
		write_cfg(REG_END_DIFF, ed);
		write_cfg(REG_START_MV, smv);
		write_cfg(REG_START_TEMP, st);
		write_cfg(REG_END_TEMP, et);
	endtask

	task automatic run_random(input int quota);
		int first, k;
		beat_t b;
		first = sent;
		while (sent - first < quota) begin
			k = $urandom_range(0, 99);
			if (k < 35) begin
				send_ticks($urandom_range(1, 40));
			end else if (k < 75) begin
				send_beat(plausible_beat(spread_kind_e'($urandom_range(0, 3)),
					$urandom_range(0, 6) != 0, $urandom_range(0, 6) == 0,
					1'($urandom_range(0, 1))));
			end else if (k < 90) begin
				send_beat(rand_beat());
			end else begin
				// not ready: one of the two qualifiers low
				b = rand_beat();
				if ($urandom_range(0, 1)) b.sample_done = 1'b0;
				else b.mode_ok = 1'b0;
				send_beat(b);
			end
			if ($urandom_range(0, 49) == 0) drain();
		end
	endtask

	initial begin
		#4000000;
		$display("tb failed");
		$finish;
	end

	initial begin
		beat_t b;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed beats at default thresholds
		b = '{default: '0};
		b.op = OP_TICK;
		send_beat(b);
		b = '{default: '1};
		b.op = OP_TICK;
		send_beat(b);
		send_beat(mk_eval(65535, 0, 15, 0, 0, 1'b0, 1'b1, 1'b0));
		send_beat(mk_eval(0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b0));
		send_beat(mk_eval(100, 65535, 3, 10, 20, 1'b1, 1'b1, 1'b0));
		send_beat(mk_eval(65535, 65036, 8, 10, 20, 1'b1, 1'b1, 1'b0));
		send_beat(mk_eval(4000, 3500, 1, 10, 20, 1'b1, 1'b1, 1'b0));
		send_beat(mk_eval(4000, 3500, 1, 10, 20, 1'b1, 1'b1, 1'b1));
		send_beat(mk_eval(3400, 3370, 15, 0, 450, 1'b1, 1'b1, 1'b0));
		send_beat(mk_eval(3500, 3000, 0, -32768, 32767, 1'b1, 1'b1, 1'b1));
		send_beat(mk_eval(3500, 3400, 7, 32767, -32768, 1'b1, 1'b1, 1'b0));
		send_beat(mk_eval(65535, 65535, 15, -1, -1, 1'b1, 1'b1, 1'b0));
		send_ticks(1);

		// session: hold expiry, start, periods with re-targets and
		// measurement pauses under a suspected failure, then repeated
		// counts while the stop condition waits on the hold timer
		repeat (12) begin
			send_ticks(10);
			send_beat(plausible_beat(SPREAD_MID, 1'b1, 1'b0, 1'b1));
		end
		repeat (10) begin
			send_ticks($urandom_range(17, 30));
			send_beat(plausible_beat(SPREAD_LARGE, 1'b1, $urandom_range(0, 4) == 0, 1'b1));
		end
		repeat (4) begin
			send_beat(plausible_beat(SPREAD_SMALL, 1'b1, 1'b0, 1'b1));
			send_ticks(40);
		end
		send_beat(plausible_beat(SPREAD_SMALL, 1'b1, 1'b0, 1'b1));
		drain();

		apply_setting(SET_TYPICAL);
		run_random(90);
		drain();
		apply_setting(SET_LOW);
		run_random(90);
		drain();
		apply_setting(SET_HIGH);
		run_random(90);
		drain();
		apply_setting(SET_TYPICAL);
		run_random(90);
		drain();

		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule
